>>> sv/cpu_usage_delta_ranker_core_macros.svh
// Assertion macros for the usage delta ranker.
`ifndef CPU_USAGE_DELTA_RANKER_CORE_MACROS_SVH
`define CPU_USAGE_DELTA_RANKER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CUDR_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define CUDR_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m failed");
`else
`define CUDR_ASSERT_IMPL(label, clk, rst, prop)
`define CUDR_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

>>> sv/cudr_pkg.sv
// Shared types and constants for the usage delta ranker.
`timescale 1ns / 1ps
package cudr_pkg;
  localparam int unsigned PID_W = 32;
  localparam int unsigned TICK_W = 48;
  localparam int unsigned SHARE_W = 10;
  localparam int unsigned PERMILLE = 1000;

  typedef enum logic [1:0] {
    CMD_LOAD_BASE = 2'd0,
    CMD_LOAD_CUR  = 2'd1,
    CMD_RANK      = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [PID_W-1:0]  pid;
    logic [TICK_W-1:0] ticks;
  } in_item_t;

  typedef struct packed {
    logic [PID_W-1:0]   row_pid;
    logic [TICK_W-1:0]  delta_ticks;
    logic [SHARE_W-1:0] share_permille;
    logic               last;
  } out_item_t;
endpackage

>>> sv/cudr_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module cudr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a write returns the old word, read data registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> sv/cudr_front.sv
// Front end: takes items and classifies them into a two-entry queue.
`timescale 1ns / 1ps
module cudr_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cudr_pkg::in_item_t in_item,
  output logic               busy,
  output logic               q_valid,
  output cudr_pkg::in_item_t q_item,
  input  logic               q_pop
);
  cudr_pkg::in_item_t slot [2];
  logic [1:0] fill;
  logic       rd_ptr;
  logic       wr_ptr;
  logic       push;

  // Unused commands are dropped here and never reach the back end.
  assign busy = (fill == 2'd2);
  assign push = start && !busy && (in_item.command != cudr_pkg::CMD_NONE);
  assign q_valid = (fill != 2'd0);
  assign q_item = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= 2'd0;
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
    end else begin
      if (push) begin
        slot[wr_ptr] <= in_item;
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

>>> sv/cudr_div.sv
// Restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module cudr_div #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         go,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);
  localparam int unsigned CW = $clog2(W + 1);
  logic [W-1:0]  rem;
  logic [W-1:0]  q;
  logic [W-1:0]  d;
  logic [CW-1:0] cnt;
  logic          run;
  logic [W:0]    trial;

  assign trial = {rem, q[W-1]} - {1'b0, d};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        rem <= '0;
        q   <= num;
        d   <= den;
        cnt <= CW'(W);
        run <= 1'b1;
      end else if (run) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          q   <= {q[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], q[W-1]};
          q   <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> sv/cudr_back.sv
// Back end: stores tables, computes deltas, sorts and emits the ranking.
`timescale 1ns / 1ps
module cudr_back #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned TICK_BITS   = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  cudr_pkg::in_item_t  q_item,
  output logic                q_pop,
  output logic                res_valid,
  output cudr_pkg::out_item_t res_item
);
  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TW = TICK_BITS + CW;
  localparam int unsigned DW = 64;

  typedef enum logic [4:0] {
    S_IDLE, S_CUR_RD, S_CUR_WT, S_BASE_RD, S_BASE_WT, S_BASE_CMP, S_ROW_WR,
    S_SORT_RA, S_SORT_RB, S_SORT_WT, S_SORT_CMP, S_SORT_WA, S_SORT_NEXT,
    S_OUT_RD, S_OUT_WT, S_OUT_MUL, S_OUT_DIV, S_OUT_WAIT, S_OUT_EMIT
  } state_t;

  state_t state;
  logic [CW-1:0] base_count, cur_count, n;
  logic [CW-1:0] i, j;
  logic [TW-1:0] total;
  logic [TICK_BITS-1:0] prior, now_t, dj;
  logic [cudr_pkg::PID_W-1:0] cur_pid, pj;
  logic found;
  logic [DW-1:0] prod;

  // RAM ports.
  logic bp_we, cp_we, rp_we;
  logic [AW-1:0] b_addr, c_addr, r_addr;
  logic [cudr_pkg::PID_W-1:0] bp_rd, cp_rd, rp_rd, rp_wd;
  logic [TICK_BITS-1:0] bt_rd, ct_rd, rd_rd, rd_wd;
  logic div_go, div_done;
  logic [DW-1:0] div_q;

  logic [TICK_BITS-1:0] in_ticks;
  assign in_ticks = q_item.ticks[TICK_BITS-1:0];

  cudr_ram #(.WIDTH(cudr_pkg::PID_W), .DEPTH(MAX_ENTRIES)) u_bp (
    .clk, .we(bp_we), .addr(b_addr), .wdata(q_item.pid), .rdata(bp_rd));
  cudr_ram #(.WIDTH(TICK_BITS), .DEPTH(MAX_ENTRIES)) u_bt (
    .clk, .we(bp_we), .addr(b_addr), .wdata(in_ticks), .rdata(bt_rd));
  cudr_ram #(.WIDTH(cudr_pkg::PID_W), .DEPTH(MAX_ENTRIES)) u_cp (
    .clk, .we(cp_we), .addr(c_addr), .wdata(q_item.pid), .rdata(cp_rd));
  cudr_ram #(.WIDTH(TICK_BITS), .DEPTH(MAX_ENTRIES)) u_ct (
    .clk, .we(cp_we), .addr(c_addr), .wdata(in_ticks), .rdata(ct_rd));
  cudr_ram #(.WIDTH(cudr_pkg::PID_W), .DEPTH(MAX_ENTRIES)) u_rp (
    .clk, .we(rp_we), .addr(r_addr), .wdata(rp_wd), .rdata(rp_rd));
  cudr_ram #(.WIDTH(TICK_BITS), .DEPTH(MAX_ENTRIES)) u_rd (
    .clk, .we(rp_we), .addr(r_addr), .wdata(rd_wd), .rdata(rd_rd));

  cudr_div #(.W(DW)) u_div (
    .clk, .rst, .go(div_go), .num(prod), .den(DW'(total)),
    .done(div_done), .quo(div_q));

  // Port control decoded from state.
  always_comb begin
    q_pop  = 1'b0;
    bp_we  = 1'b0;
    cp_we  = 1'b0;
    rp_we  = 1'b0;
    div_go = 1'b0;
    b_addr = i[AW-1:0];
    c_addr = i[AW-1:0];
    r_addr = i[AW-1:0];
    rp_wd  = cur_pid;
    rd_wd  = (found && prior > now_t) ? '0 : now_t - (found ? prior : '0);
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          case (q_item.command)
            cudr_pkg::CMD_LOAD_BASE: begin
              q_pop = 1'b1;
              b_addr = base_count[AW-1:0];
              bp_we = (base_count < CW'(MAX_ENTRIES));
            end
            cudr_pkg::CMD_LOAD_CUR: begin
              q_pop = 1'b1;
              c_addr = cur_count[AW-1:0];
              cp_we = (cur_count < CW'(MAX_ENTRIES));
            end
            cudr_pkg::CMD_RANK: q_pop = 1'b1;
            default: q_pop = 1'b1;
          endcase
        end
      end
      // The address is held through the wait cycle so the registered read stays put.
      S_BASE_RD, S_BASE_WT: b_addr = j[AW-1:0];
      S_ROW_WR: rp_we = 1'b1;
      S_SORT_RB, S_SORT_WT: r_addr = j[AW-1:0];
      S_SORT_WA: begin
        rp_we = 1'b1;
        rp_wd = pj;
        rd_wd = dj;
      end
      S_SORT_NEXT: begin
        r_addr = j[AW-1:0];
        rp_we  = 1'b1;
        rp_wd  = cur_pid;
        rd_wd  = now_t;
      end
      S_OUT_DIV: div_go = 1'b1;
      default: ;
    endcase
  end

  // Sequencer: gather rows, exchange sort, then emit with shares.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      base_count <= '0;
      cur_count  <= '0;
      total      <= '0;
      res_valid  <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.command == cudr_pkg::CMD_LOAD_BASE && bp_we) begin
              base_count <= base_count + 1'b1;
            end
            if (q_item.command == cudr_pkg::CMD_LOAD_CUR && cp_we) begin
              cur_count <= cur_count + 1'b1;
            end
            if (q_item.command == cudr_pkg::CMD_RANK) begin
              n     <= cur_count;
              i     <= '0;
              total <= '0;
              if (cur_count == '0) begin
                base_count <= '0;
              end else begin
                state <= S_CUR_RD;
              end
            end
          end
        end
        S_CUR_RD: state <= S_CUR_WT;
        S_CUR_WT: begin
          cur_pid <= cp_rd;
          now_t   <= ct_rd;
          found   <= 1'b0;
          j       <= '0;
          state   <= (base_count == '0) ? S_ROW_WR : S_BASE_RD;
        end
        S_BASE_RD: state <= S_BASE_WT;
        S_BASE_WT: state <= S_BASE_CMP;
        S_BASE_CMP: begin
          if (bp_rd == cur_pid) begin
            found  <= 1'b1;
            prior  <= bt_rd;
            state  <= S_ROW_WR;
          end else if (j + 1'b1 == base_count) begin
            state <= S_ROW_WR;
          end else begin
            j     <= j + 1'b1;
            state <= S_BASE_RD;
          end
        end
        S_ROW_WR: begin
          total <= total + TW'(rd_wd);
          if (i + 1'b1 == n) begin
            i     <= '0;
            j     <= CW'(1);
            state <= (n == CW'(1)) ? S_OUT_RD : S_SORT_RA;
          end else begin
            i     <= i + 1'b1;
            state <= S_CUR_RD;
          end
        end
        S_SORT_RA: state <= S_SORT_RB;
        S_SORT_RB: begin
          cur_pid <= rp_rd;
          now_t   <= rd_rd;
          state   <= S_SORT_WT;
        end
        S_SORT_WT: state <= S_SORT_CMP;
        S_SORT_CMP: begin
          pj <= rp_rd;
          dj <= rd_rd;
          if (rd_rd > now_t) begin
            state <= S_SORT_WA;
          end else if (j + 1'b1 == n) begin
            if (i + CW'(2) == n) begin
              i     <= '0;
              state <= S_OUT_RD;
            end else begin
              i     <= i + 1'b1;
              j     <= i + CW'(2);
              state <= S_SORT_RA;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_SORT_RA;
          end
        end
        S_SORT_WA: state <= S_SORT_NEXT;
        S_SORT_NEXT: begin
          // Row a now holds the larger delta; continue scanning.
          cur_pid <= pj;
          now_t   <= dj;
          if (j + 1'b1 == n) begin
            if (i + CW'(2) == n) begin
              i     <= '0;
              state <= S_OUT_RD;
            end else begin
              i     <= i + 1'b1;
              j     <= i + CW'(2);
              state <= S_SORT_RA;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_SORT_RA;
          end
        end
        S_OUT_RD: state <= S_OUT_WT;
        S_OUT_WT: state <= S_OUT_MUL;
        S_OUT_MUL: begin
          cur_pid <= rp_rd;
          now_t   <= rd_rd;
          prod    <= DW'(rd_rd) * DW'(cudr_pkg::PERMILLE);
          state   <= S_OUT_DIV;
        end
        S_OUT_DIV: state <= (total == '0) ? S_OUT_EMIT : S_OUT_WAIT;
        S_OUT_WAIT: if (div_done) state <= S_OUT_EMIT;
        S_OUT_EMIT: begin
          res_valid <= 1'b1;
          res_item.row_pid <= cur_pid;
          res_item.delta_ticks <= cudr_pkg::TICK_W'(now_t);
          res_item.share_permille <= (total == '0) ? '0 :
                                     cudr_pkg::SHARE_W'(div_q);
          res_item.last <= (i + 1'b1 == n);
          if (i + 1'b1 == n) begin
            base_count <= '0;
            cur_count  <= '0;
            state      <= S_IDLE;
          end else begin
            i     <= i + 1'b1;
            state <= S_OUT_RD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> sv/cpu_usage_delta_ranker_core.sv
// Top level of the usage delta ranker: front queue plus rank engine.
//
//   channel   | handshake           | payload
//   ----------+---------------------+-----------------------------
//   command   | start && !busy      | in_item  (command, pid, ticks)
//   result    | res_valid strobe    | res_item (row_pid, delta, share, last)
//
// Loads are taken by the back end while idle; the two-entry queue takes one item
// a cycle until full. A rank gathers rows (each current row scans the b baseline
// entries), runs an exchange sort over pairs, then emits each row with its share
// from the 64-step share divider, whose result is not awaited when the total is
// zero. Reset is synchronous and clears counts and control only. The receiver
// cannot stall; busy holds off items.
`timescale 1ns / 1ps
`include "cpu_usage_delta_ranker_core_macros.svh"
module cpu_usage_delta_ranker_core #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned TICK_BITS   = 48
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  cudr_pkg::in_item_t  in_item,
  output logic                busy,
  output logic                res_valid,
  output cudr_pkg::out_item_t res_item
);
  logic               q_valid, q_pop;
  cudr_pkg::in_item_t q_item;

  cudr_front u_front (
    .clk, .rst, .start, .in_item, .busy, .q_valid, .q_item, .q_pop);

  cudr_back #(.MAX_ENTRIES(MAX_ENTRIES), .TICK_BITS(TICK_BITS)) u_back (
    .clk, .rst, .q_valid, .q_item, .q_pop, .res_valid, .res_item);

  `CUDR_ASSERT_NEVER(a_pop_empty, clk, rst, q_pop && !q_valid)
  `CUDR_ASSERT_IMPL(a_share_range, clk, rst,
    res_valid |-> (res_item.share_permille <= 10'd1000))
endmodule

>>> tb/tb.sv
// Self-checking testbench for the CPU usage delta ranker core.
`timescale 1ns / 1ps
module tb;
  import cudr_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic start;
  in_item_t in_item;
  logic busy;
  logic res_valid;
  out_item_t res_item;

  cpu_usage_delta_ranker_core dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .res_valid(res_valid), .res_item(res_item)
  );

  // Predictor state: both sample tables.
  logic [PID_W-1:0] base_pids[TABLE_DEPTH];
  logic [TICK_W-1:0] base_ticks[TABLE_DEPTH];
  int unsigned base_used;
  logic [PID_W-1:0] cur_pids[TABLE_DEPTH];
  logic [TICK_W-1:0] cur_ticks[TABLE_DEPTH];
  int unsigned cur_used;

  in_item_t pending_items[$];
  out_item_t expected_rows[$];
  bit failed;
  bit hold_for_drain;
  int unsigned gap_left;
  int unsigned cycle_count;
  bit stimulus_done;

  // Apply one accepted item to the predictor and queue any ranked rows.
  task automatic predict_ranking(input in_item_t item);
    logic [PID_W-1:0] row_pids[TABLE_DEPTH];
    logic [TICK_W-1:0] row_deltas[TABLE_DEPTH];
    logic [63:0] total;
    logic [63:0] share;
    logic [TICK_W-1:0] prior;
    logic [TICK_W-1:0] swap_delta;
    logic [PID_W-1:0] swap_pid;
    out_item_t row;
    case (cmd_t'(item.command))
      CMD_LOAD_BASE: begin
        if (base_used < TABLE_DEPTH) begin
          base_pids[base_used] = item.pid;
          base_ticks[base_used] = item.ticks;
          base_used++;
        end
      end
      CMD_LOAD_CUR: begin
        if (cur_used < TABLE_DEPTH) begin
          cur_pids[cur_used] = item.pid;
          cur_ticks[cur_used] = item.ticks;
          cur_used++;
        end
      end
      CMD_RANK: begin
        total = 0;
        for (int k = 0; k < cur_used; k++) begin
          prior = 0;
          for (int b = 0; b < base_used; b++) begin
            if (base_pids[b] == cur_pids[k]) begin
              prior = base_ticks[b];
              break;
            end
          end
          row_pids[k] = cur_pids[k];
          row_deltas[k] = (cur_ticks[k] >= prior) ? cur_ticks[k] - prior : '0;
          total += row_deltas[k];
        end
        // Exchange sort, swapping only on a strictly larger later delta.
        for (int a = 0; a < cur_used; a++) begin
          for (int b = a + 1; b < cur_used; b++) begin
            if (row_deltas[b] > row_deltas[a]) begin
              swap_delta = row_deltas[a];
              swap_pid = row_pids[a];
              row_deltas[a] = row_deltas[b];
              row_pids[a] = row_pids[b];
              row_deltas[b] = swap_delta;
              row_pids[b] = swap_pid;
            end
          end
        end
        for (int k = 0; k < cur_used; k++) begin
          share = (total == 0) ? 64'd0 : (64'(row_deltas[k]) * PERMILLE) / total;
          row.row_pid = row_pids[k];
          row.delta_ticks = row_deltas[k];
          row.share_permille = share[SHARE_W-1:0];
          row.last = (k + 1 == cur_used);
          expected_rows.push_back(row);
        end
        base_used = 0;
        cur_used = 0;
      end
      default: begin
      end
    endcase
  endtask

  function automatic in_item_t make_item(input cmd_t cmd, input logic [PID_W-1:0] pid,
                                         input logic [TICK_W-1:0] ticks);
    in_item_t item;
    item.command = cmd;
    item.pid = pid;
    item.ticks = ticks;
    return item;
  endfunction

  function automatic logic [TICK_W-1:0] random_ticks();
    logic [TICK_W-1:0] value;
    value = TICK_W'({$urandom(), $urandom()});
    case ($urandom_range(0, 3))
      0: value = value & 48'hFFFF;
      1: value = value & 48'hFF_FFFF_FFFF;
      default: begin
      end
    endcase
    return value;
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // Clock.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stimulus: directed cases, then random sample rounds.
  initial begin
    logic [PID_W-1:0] pid_pool[8];
    int unsigned entries;
    cmd_t cmd_pick;
    logic [PID_W-1:0] pid_pick;
    rst = 1;
    base_used = 0;
    cur_used = 0;
    failed = 0;
    stimulus_done = 0;
    // Rank on empty tables gives no rows.
    pending_items.push_back(make_item(CMD_RANK, '0, '0));
    // Extremes of the fields, a clamp to zero and an unmatched pid.
    pending_items.push_back(make_item(CMD_LOAD_BASE, '1, '1));
    pending_items.push_back(make_item(CMD_LOAD_BASE, 32'd7, 48'd100));
    pending_items.push_back(make_item(CMD_LOAD_BASE, 32'd7, 48'd5));
    pending_items.push_back(make_item(CMD_LOAD_CUR, '1, '1));
    pending_items.push_back(make_item(CMD_LOAD_CUR, 32'd7, 48'd50));
    pending_items.push_back(make_item(CMD_LOAD_CUR, '0, '1));
    pending_items.push_back(make_item(CMD_LOAD_CUR, 32'd9, 48'd0));
    pending_items.push_back(make_item(CMD_NONE, 32'hA5A5_5A5A, 48'h5555_AAAA_5555));
    pending_items.push_back(make_item(CMD_RANK, 32'h5A5A_A5A5, 48'hAAAA_5555_AAAA));
    // All deltas zero: total is zero, so are the shares.
    pending_items.push_back(make_item(CMD_LOAD_BASE, 32'd3, 48'd10));
    pending_items.push_back(make_item(CMD_LOAD_CUR, 32'd3, 48'd10));
    pending_items.push_back(make_item(CMD_LOAD_CUR, 32'd4, 48'd0));
    pending_items.push_back(make_item(CMD_RANK, '0, '0));
    // Single row takes the whole share.
    pending_items.push_back(make_item(CMD_LOAD_CUR, 32'd1, 48'd12345));
    pending_items.push_back(make_item(CMD_RANK, '0, '0));
    // Overfill both tables; extra loads are dropped.
    for (int k = 0; k < TABLE_DEPTH + 3; k++) begin
      pending_items.push_back(make_item(CMD_LOAD_BASE, k,
                                        TICK_W'($urandom_range(0, 1000))));
      pending_items.push_back(make_item(CMD_LOAD_CUR, k + 2,
                                        TICK_W'($urandom_range(0, 5000))));
    end
    pending_items.push_back(make_item(CMD_RANK, '0, '0));
    // Random rounds with small tables and a shared pid pool for matches.
    for (int round = 0; round < 23; round++) begin
      for (int p = 0; p < 8; p++) pid_pool[p] = $urandom();
      entries = $urandom_range(0, 5);
      for (int k = 0; k < entries; k++)
        pending_items.push_back(make_item(CMD_LOAD_BASE, pid_pool[$urandom_range(0, 7)],
                                          random_ticks()));
      entries = $urandom_range(0, 6);
      for (int k = 0; k < entries; k++) begin
        cmd_pick = ($urandom_range(0, 9) == 0) ? CMD_NONE : CMD_LOAD_CUR;
        pid_pick = ($urandom_range(0, 4) == 0) ? $urandom() : pid_pool[$urandom_range(0, 7)];
        pending_items.push_back(make_item(cmd_pick, pid_pick, random_ticks()));
      end
      pending_items.push_back(make_item(CMD_RANK, $urandom(), random_ticks()));
    end
    repeat (12) @(posedge clk);
    rst <= 0;
    wait (pending_items.size() == 0);
    stimulus_done = 1;
  end

  // Driver: presents items with random gaps and one full drain pause.
  always @(posedge clk) begin
    if (rst) begin
      start <= 0;
      in_item <= '0;
      gap_left <= 0;
      hold_for_drain <= 0;
    end else if (start && !busy) begin
      predict_ranking(in_item);
      void'(pending_items.pop_front());
      start <= 0;
      gap_left <= pick_gap();
      if (pending_items.size() == 40) hold_for_drain <= 1;
    end else if (!start) begin
      if (hold_for_drain) begin
        if (expected_rows.size() == 0 && !busy) hold_for_drain <= 0;
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items[0];
        start <= 1;
      end
    end
  end

  // Monitor: compares each strobed row against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && res_valid) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected row pid=%h delta=%h share=%0d last=%b", $time,
                 res_item.row_pid, res_item.delta_ticks, res_item.share_permille,
                 res_item.last);
        failed <= 1;
      end else begin
        want = expected_rows.pop_front();
        if (res_item !== want) begin
          $display("%0t: row mismatch expected pid=%h delta=%h share=%0d last=%b",
                   $time, want.row_pid, want.delta_ticks, want.share_permille, want.last);
          $display("%0t:              actual   pid=%h delta=%h share=%0d last=%b",
                   $time, res_item.row_pid, res_item.delta_ticks,
                   res_item.share_permille, res_item.last);
          failed <= 1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= rst ? 0 : cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stimulus_done);
    wait (expected_rows.size() == 0);
    repeat (2000) @(posedge clk);
    if (!failed && expected_rows.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
